// ----- rtl/keyword_line_matcher_core_assert.svh -----
// Assertion macros shared by the keyword line matcher RTL.
`ifndef KEYWORD_LINE_MATCHER_CORE_ASSERT_SVH
`define KEYWORD_LINE_MATCHER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define KLM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define KLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/klm_pkg.sv -----
// Package for the keyword line matcher: constants, types and byte helpers.
package klm_pkg;

    localparam int MAX_KEY_BYTES_DEF    = 16;
    localparam int LINE_NUMBER_BITS_DEF = 32;
    localparam int KEY_REG_BYTES        = 16;
    localparam int BYTE_W               = 8;
    localparam int CFG_DATA_W           = 64;
    localparam int CFG_IDX_W            = 3;
    localparam int KEY_LEN_W            = 5;
    localparam int OUT_NUM_W            = 32;
    localparam int M_TDATA_W            = 40;
    localparam int CMP_W                = 8;

    localparam logic [BYTE_W-1:0] UNDERSCORE = 8'h5F;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_LOW    = 3'd0,
        REG_KEY_HIGH   = 3'd1,
        REG_KEY_LENGTH = 3'd2,
        REG_CASE_SENS  = 3'd3,
        REG_WHOLE_WORD = 3'd4
    } cfg_reg_t;

    // Per-cell compare status for the byte entering the cell
    typedef struct packed {
        logic eq;
        logic word;
    } cell_stat_t;

    // One finished-line result
    typedef struct packed {
        logic [OUT_NUM_W-1:0] number;
        logic                 matched;
    } line_result_t;

    function automatic logic is_word_byte(input logic [BYTE_W-1:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h61 && b <= 8'h7A) || (b == UNDERSCORE);
    endfunction

    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                    input logic fold_en);
        logic [BYTE_W-1:0] r;
        r = b;
        if (fold_en && b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

// ----- rtl/keyword_line_matcher_core.sv -----
// Keyword line matcher top level: config registers, cell chain and line control.
//
// Usage:
//   s_ channel carries text one byte per transfer: s_tdata is the byte,
//   s_tlast marks the last byte of a line, s_tuser marks the first byte of a
//   file (line numbering restarts at 1, any unfinished line is dropped).
//   m_ channel gives one transfer per finished line: matched flag and the
//   one-based, saturating line number within the file.
//   cfg_ channel writes the keyword, its length, case and whole-word modes;
//   cfg_ready is always high. Write it only while no line is in flight.
// Timing:
//   One byte per cycle sustained while s_tready is high; the whole window
//   compare runs in the cell chain in the cycle a byte is taken. The line
//   result is registered in the output buffer before it appears on m_.
// Reset and stall:
//   aresetn clears the registers, line state and line counter. When m_tready
//   is low, results queue in the output register and a skid stage; s_tready
//   drops only when both are full, so no result is lost.
module keyword_line_matcher_core #(
    parameter int MAX_KEY_BYTES    = klm_pkg::MAX_KEY_BYTES_DEF,
    parameter int LINE_NUMBER_BITS = klm_pkg::LINE_NUMBER_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: line_byte[7:0]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [klm_pkg::BYTE_W-1:0]        s_tdata,
    input  logic                              s_tlast,
    // s_tuser: file_start[0]
    input  logic                              s_tuser,
    // m_tdata: line_matched[0], line_number[32:1], zero pad[39:33]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [klm_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [klm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [klm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import klm_pkg::*;

    localparam int SEEN_W = $clog2(MAX_KEY_BYTES + 2);
    localparam int IDX_W  = $clog2(MAX_KEY_BYTES + 1);
    localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_KEY_BYTES + 1);

    // Configuration registers
    logic [CFG_DATA_W-1:0] key_low_reg, key_high_reg;
    logic [KEY_LEN_W-1:0]  key_len_reg;
    logic                  case_sens_reg, word_bound_reg;

    // Line state
    logic [SEEN_W-1:0]           seen_reg, seen_next;
    logic                        pend_reg, pend_next;
    logic                        found_reg, found_next;
    logic [LINE_NUMBER_BITS-1:0] cnt_reg, cnt_next;

    logic                           accept, push, buf_space;
    logic [KEY_REG_BYTES*BYTE_W-1:0] key_vec;
    logic [BYTE_W-1:0]              win [MAX_KEY_BYTES];
    cell_stat_t                     stat [MAX_KEY_BYTES];
    logic [MAX_KEY_BYTES-1:0]       term;
    logic [MAX_KEY_BYTES:0]         word_vec;
    logic [SEEN_W-1:0]              seen_eff, seen_inc;
    logic                           pend_eff, found_eff;
    logic                           key_ok, hit, edge_ok, pend_hit;
    logic [LINE_NUMBER_BITS-1:0]    cnt_base, cnt_inc;
    line_result_t                   res, out_res;

    assign accept    = s_tvalid & s_tready;
    assign s_tready  = buf_space;
    assign cfg_ready = 1'b1;
    assign key_vec   = {key_high_reg, key_low_reg};

    // Take configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            key_len_reg    <= '0;
            case_sens_reg  <= 1'b0;
            word_bound_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_KEY_LOW:    key_low_reg    <= cfg_data;
                REG_KEY_HIGH:   key_high_reg   <= cfg_data;
                REG_KEY_LENGTH: key_len_reg    <= cfg_data[KEY_LEN_W-1:0];
                REG_CASE_SENS:  case_sens_reg  <= cfg_data[0];
                REG_WHOLE_WORD: word_bound_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Cell chain: cell i sees the byte that becomes recent byte i
    for (genvar i = 0; i < MAX_KEY_BYTES; i++) begin : g_cell
        logic [CMP_W-1:0]  kj;
        logic [BYTE_W-1:0] key_sel;
        logic [BYTE_W-1:0] din;

        // Cell i lines up with keyword byte length-1-i
        assign kj      = CMP_W'(key_len_reg) - CMP_W'(i + 1);
        assign key_sel = (kj[CMP_W-1:4] != '0) ? '0 : key_vec[8*kj[3:0] +: 8];
        if (i == 0) begin : g_head
            assign din = s_tdata;
        end else begin : g_body
            assign din = win[i-1];
        end

        klm_cell u_cell (
            .aclk     (aclk),
            .shift_en (accept),
            .fold_en  (~case_sens_reg),
            .byte_in  (din),
            .key_byte (key_sel),
            .byte_out (win[i]),
            .stat     (stat[i])
        );

        assign term[i]     = (CMP_W'(i) >= CMP_W'(key_len_reg)) | stat[i].eq;
        assign word_vec[i] = stat[i].word;
    end
    assign word_vec[MAX_KEY_BYTES] = is_word_byte(win[MAX_KEY_BYTES-1]);

    // Match decision on the window after this byte enters
    always_comb begin
        seen_eff  = s_tuser ? '0 : seen_reg;
        pend_eff  = pend_reg & ~s_tuser;
        found_eff = found_reg & ~s_tuser;
        seen_inc  = (seen_eff == SEEN_MAX) ? seen_eff : seen_eff + 1'b1;
        key_ok    = (key_len_reg != '0) &&
                    (CMP_W'(key_len_reg) <= CMP_W'(MAX_KEY_BYTES)) &&
                    (CMP_W'(seen_inc) >= CMP_W'(key_len_reg));
        hit       = key_ok & (&term);
        edge_ok   = (CMP_W'(seen_inc) == CMP_W'(key_len_reg)) ||
                    !word_vec[IDX_W'(key_len_reg)];
        pend_hit  = pend_eff & ~is_word_byte(s_tdata);
        found_next = found_eff | pend_hit |
                     (hit & (~word_bound_reg | (edge_ok & s_tlast)));
        pend_next  = hit & word_bound_reg & edge_ok & ~s_tlast;
        seen_next  = seen_inc;
        cnt_base   = s_tuser ? '0 : cnt_reg;
        cnt_inc    = (&cnt_base) ? cnt_base : cnt_base + 1'b1;
        cnt_next   = s_tlast ? cnt_inc : cnt_base;
    end

    // Update line state on each transfer; clear it at line end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg  <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
            cnt_reg   <= '0;
        end else if (accept) begin
            cnt_reg <= cnt_next;
            if (s_tlast) begin
                seen_reg  <= '0;
                pend_reg  <= 1'b0;
                found_reg <= 1'b0;
            end else begin
                seen_reg  <= seen_next;
                pend_reg  <= pend_next;
                found_reg <= found_next;
            end
        end
    end

    // Emit one result per finished line
    assign push       = accept & s_tlast;
    assign res.matched = found_next;
    assign res.number  = OUT_NUM_W'(cnt_inc);

    klm_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (res),
        .space     (buf_space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = M_TDATA_W'({out_res.number, out_res.matched});

`include "keyword_line_matcher_core_assert.svh"

    `KLM_ASSERT_NEXT(a_line_end_result, accept && s_tlast, m_tvalid, "line end gave no result")
    `KLM_ASSERT_NEXT(a_line_end_clear, accept && s_tlast, seen_reg == '0 && !pend_reg && !found_reg, "line state not cleared")
    `KLM_ASSERT_NEXT(a_file_restart, accept && s_tuser && !s_tlast, cnt_reg == '0, "file start did not restart numbering")
    `KLM_ASSERT_SAME(a_pend_whole_word, pend_reg, seen_reg != '0, "pending candidate outside a line")

endmodule

// ----- rtl/klm_cell.sv -----
// One window cell: holds a recent byte and compares the byte entering it.
module klm_cell (
    input  logic                        aclk,
    input  logic                        shift_en,
    input  logic                        fold_en,
    input  logic [klm_pkg::BYTE_W-1:0]  byte_in,
    input  logic [klm_pkg::BYTE_W-1:0]  key_byte,
    output logic [klm_pkg::BYTE_W-1:0]  byte_out,
    output klm_pkg::cell_stat_t         stat
);
    import klm_pkg::*;

    logic [BYTE_W-1:0] byte_reg;

    // Compare and classify the byte this cell takes on the transfer
    always_comb begin
        stat.eq   = (fold_byte(byte_in, fold_en) == fold_byte(key_byte, fold_en));
        stat.word = is_word_byte(byte_in);
    end

    // Advance the window by one byte per transfer
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

endmodule

// ----- rtl/klm_out_buf.sv -----
// Two-entry output buffer: output register plus skid stage for line results.
module klm_out_buf (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  klm_pkg::line_result_t  push_data,
    output logic                   space,
    output logic                   out_valid,
    input  logic                   out_ready,
    output klm_pkg::line_result_t  out_data
);
    import klm_pkg::*;

    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    line_result_t out_data_reg, out_data_next;
    line_result_t skid_data_reg, skid_data_next;
    logic         pop;

    assign pop = out_valid_reg & out_ready;

    // Route new results to the output register or park them in the skid stage
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign space     = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
